@@ rtl/core/tmcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types, constants and the CGA palette for the text-mode cell renderer.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  // Default geometry
  localparam int GLYPH_COUNT_DEF  = 256;
  localparam int GLYPH_LINES_DEF  = 16;
  localparam int TEXT_COLUMNS_DEF = 80;

  // Port widths
  localparam int IN_DATA_W  = 48;  // 44 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 7;

  // Opcodes (in_tuser)
  localparam logic OP_RENDER     = 1'b0;
  localparam logic OP_FONT_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_VISIBLE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_ROW        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_COLUMN     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_FIRST_LINE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_LAST_LINE  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BLINK_ENABLE      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TALL_FONT         = 3'd6;

  // Timing thresholds on the frame counter
  localparam logic [4:0] CURSOR_ON_LIMIT = 5'h0f;
  localparam logic [5:0] BLINK_OFF_START = 6'h1f;

  // Font store access
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] glyph;
    logic [3:0] line;
    logic [7:0] data;
  } font_req_t;

  function automatic logic [5:0] rgb222(input logic [1:0] r, input logic [1:0] g,
                                        input logic [1:0] b);
    rgb222 = {b, g, r};
  endfunction

  // 16-color CGA palette (index 6 is the brown variant)
  function automatic logic [5:0] cga_color(input logic [3:0] idx);
    logic [5:0] c;
    case (idx)
      4'd0:    c = rgb222(2'd0, 2'd0, 2'd0);
      4'd1:    c = rgb222(2'd0, 2'd0, 2'd2);
      4'd2:    c = rgb222(2'd0, 2'd2, 2'd0);
      4'd3:    c = rgb222(2'd0, 2'd2, 2'd2);
      4'd4:    c = rgb222(2'd2, 2'd0, 2'd0);
      4'd5:    c = rgb222(2'd2, 2'd0, 2'd2);
      4'd6:    c = rgb222(2'd2, 2'd1, 2'd0);
      4'd7:    c = rgb222(2'd2, 2'd2, 2'd2);
      4'd8:    c = rgb222(2'd1, 2'd1, 2'd1);
      4'd9:    c = rgb222(2'd1, 2'd1, 2'd3);
      4'd10:   c = rgb222(2'd1, 2'd3, 2'd1);
      4'd11:   c = rgb222(2'd1, 2'd3, 2'd3);
      4'd12:   c = rgb222(2'd3, 2'd1, 2'd1);
      4'd13:   c = rgb222(2'd3, 2'd1, 2'd3);
      4'd14:   c = rgb222(2'd3, 2'd3, 2'd1);
      default: c = rgb222(2'd3, 2'd3, 2'd3);
    endcase
    cga_color = c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/text_mode_cell_renderer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_cell_renderer
// Draws one 8-pixel slice of a PC text-mode cell in CGA colors (RGB222).
// ----------------------------------------------------------------------------
// One word in per cycle while in_tready is high, one word out per render.
// in_tuser = 0 asks for a slice of the cell at (column, scan_line); in_tuser =
// 1 writes font_byte to the font RAM at (char_code, glyph_line) and produces
// no output word. Renders pass the font RAM read register, then the pixel
// output register; the pipeline keeps a full rate of one word per cycle as
// long as out_tready stays high. When it drops, the output register holds; an
// empty stage 1 still fills. The frame counter steps on every render of column
// 0, scan line 0 and times the cursor blink (on for 15 of 32 frames) and
// attribute blink (off for 33 of 64 frames). Columns at or past TEXT_COLUMNS
// render black. The font RAM is not cleared: load every glyph line before it
// is displayed. Configuration writes belong to idle time only.
// ----------------------------------------------------------------------------
module text_mode_cell_renderer #(
  parameter int GLYPH_COUNT  = tmcr_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_LINES  = tmcr_pkg::GLYPH_LINES_DEF,
  parameter int TEXT_COLUMNS = tmcr_pkg::TEXT_COLUMNS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [7:0] char_code, [15:8] attribute, [22:16] column, [31:23] scan_line,
  // [35:32] glyph_line, [43:36] font_byte, [47:44] zero
  input  wire  [tmcr_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] opcode
  input  wire                                in_tuser,
  // Output stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [47:0] pixels, leftmost pixel in [5:0]
  output logic [tmcr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration
  input  wire                                cfg_we,
  input  wire  [tmcr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [tmcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic       cursor_visible_r;
  logic [5:0] cursor_row_r;
  logic [6:0] cursor_column_r;
  logic [4:0] cursor_first_r;
  logic [4:0] cursor_last_r;
  logic       blink_enable_r;
  logic       tall_font_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_visible_r <= 1'b0;
      cursor_row_r     <= '0;
      cursor_column_r  <= '0;
      cursor_first_r   <= '0;
      cursor_last_r    <= '0;
      blink_enable_r   <= 1'b1;
      tall_font_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        tmcr_pkg::REG_CURSOR_VISIBLE:    cursor_visible_r <= cfg_wdata[0];
        tmcr_pkg::REG_CURSOR_ROW:        cursor_row_r     <= cfg_wdata[5:0];
        tmcr_pkg::REG_CURSOR_COLUMN:     cursor_column_r  <= cfg_wdata[6:0];
        tmcr_pkg::REG_CURSOR_FIRST_LINE: cursor_first_r   <= cfg_wdata[4:0];
        tmcr_pkg::REG_CURSOR_LAST_LINE:  cursor_last_r    <= cfg_wdata[4:0];
        tmcr_pkg::REG_BLINK_ENABLE:      blink_enable_r   <= cfg_wdata[0];
        tmcr_pkg::REG_TALL_FONT:         tall_font_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input word fields
  logic [7:0] char_code;
  logic [7:0] attribute;
  logic [6:0] column;
  logic [8:0] scan_line;
  logic [3:0] glyph_line;
  logic [7:0] font_byte;

  assign char_code  = in_tdata[7:0];
  assign attribute  = in_tdata[15:8];
  assign column     = in_tdata[22:16];
  assign scan_line  = in_tdata[31:23];
  assign glyph_line = in_tdata[35:32];
  assign font_byte  = in_tdata[43:36];

  // Pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;
  logic accept;
  logic is_render;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;
  assign is_render = accept && (in_tuser == tmcr_pkg::OP_RENDER);

  // Frame counter: steps before the slice that triggers it is drawn
  logic [5:0] frame_count_r;
  logic [5:0] frame_count_nxt;

  always_comb begin
    frame_count_nxt = frame_count_r;
    if (is_render && scan_line == 9'd0 && column == 7'd0) begin
      frame_count_nxt = frame_count_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else begin
      frame_count_r <= frame_count_nxt;
    end
  end

  // Glyph line and text row from the scan line (8 or 16 lines per glyph)
  logic [3:0] line;
  logic [5:0] row;
  logic [4:0] height;

  always_comb begin
    if (tall_font_r) begin
      line   = scan_line[3:0];
      row    = {1'b0, scan_line[8:4]};
      height = 5'd16;
    end else begin
      line   = {1'b0, scan_line[2:0]};
      row    = scan_line[8:3];
      height = 5'd8;
    end
  end

  // Cursor shape: a block that runs past the glyph is moved up to end on the
  // last glyph line, keeping its height
  logic signed [6:0] cur_first;
  logic signed [6:0] cur_last;
  logic signed [6:0] h_s;
  logic signed [6:0] line_s;
  logic              on_line;

  always_comb begin
    h_s       = signed'({2'b00, height});
    line_s    = signed'({3'b000, line});
    cur_first = signed'({2'b00, cursor_first_r});
    cur_last  = signed'({2'b00, cursor_last_r});
    if (cur_first <= cur_last && cur_last >= h_s) begin
      cur_first = h_s - 7'sd1 - (cur_last - cur_first);
      cur_last  = h_s - 7'sd1;
    end
    on_line = (cur_last >= cur_first) && (cur_first >= 7'sd0) &&
              (cur_first < h_s) && (cur_last < h_s) &&
              (line_s >= cur_first) && (line_s <= cur_last);
  end

  logic       cursor_hit;
  logic       blink_off;
  logic [3:0] bg_idx;
  logic [5:0] bg_color;
  logic [5:0] fg_color;
  logic       col_blank;

  always_comb begin
    cursor_hit = cursor_visible_r && (cursor_row_r == row) &&
                 (cursor_column_r == column) &&
                 (frame_count_nxt[4:0] < tmcr_pkg::CURSOR_ON_LIMIT) && on_line;
    // Bit 7 is blink when enabled, else the bright background bit
    blink_off  = blink_enable_r && attribute[7] &&
                 (frame_count_nxt >= tmcr_pkg::BLINK_OFF_START);
    bg_idx     = blink_enable_r ? {1'b0, attribute[6:4]} : attribute[7:4];
    bg_color   = tmcr_pkg::cga_color(bg_idx);
    fg_color   = blink_off ? bg_color : tmcr_pkg::cga_color(attribute[3:0]);
    col_blank  = {1'b0, column} >= 8'(TEXT_COLUMNS);
  end

  // Font RAM: writes and render reads both issue on acceptance, so accesses
  // land in word order
  tmcr_pkg::font_req_t font_req;
  logic [7:0]          font_row;

  always_comb begin
    font_req.wr_en = accept && (in_tuser == tmcr_pkg::OP_FONT_WRITE);
    font_req.rd_en = is_render;
    font_req.glyph = char_code;
    font_req.line  = font_req.wr_en ? glyph_line : line;
    font_req.data  = font_byte;
  end

  tmcr_font_store #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_LINES (GLYPH_LINES)
  ) u_font_store (
    .clk     (clk),
    .req     (font_req),
    .rd_data (font_row)
  );

  // Stage 1: colors and cursor, lined up with the RAM read data
  logic [5:0] s1_fg_r;
  logic [5:0] s1_bg_r;
  logic       s1_cursor_r;
  logic       s1_blank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= is_render;
    end
  end

  always_ff @(posedge clk) begin
    if (is_render) begin
      s1_fg_r     <= fg_color;
      s1_bg_r     <= bg_color;
      s1_cursor_r <= cursor_hit;
      s1_blank_r  <= col_blank;
    end
  end

  // Pixel expansion, bit 7 of the font row is the leftmost pixel
  logic [7:0]                      row_bits;
  logic [tmcr_pkg::OUT_DATA_W-1:0] pixels_nxt;

  always_comb begin
    row_bits = font_row | {8{s1_cursor_r}};
    for (int k = 0; k < 8; k++) begin
      pixels_nxt[6*k +: 6] = row_bits[7-k] ? s1_fg_r : s1_bg_r;
    end
    if (s1_blank_r) begin
      pixels_nxt = '0;
    end
  end

  // Output register
  logic [tmcr_pkg::OUT_DATA_W-1:0] out_pixels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_pixels_r <= pixels_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixels_r;

endmodule
`default_nettype wire

@@ rtl/core/tmcr_font_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_font_store
// Glyph RAM, one byte per glyph line, with wrapped addressing and registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module tmcr_font_store #(
  parameter int GLYPH_COUNT = tmcr_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_LINES = tmcr_pkg::GLYPH_LINES_DEF
) (
  input  wire                      clk,
  input  wire tmcr_pkg::font_req_t req,
  output logic [7:0]               rd_data
);

  localparam int DEPTH  = GLYPH_COUNT * GLYPH_LINES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        glyph_wrap;
  logic [3:0]        line_wrap;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        rd_data_r;

  // Codes at most twice the store size: one compare and subtract wraps them
  always_comb begin
    if ({1'b0, req.glyph} >= 9'(GLYPH_COUNT)) begin
      glyph_wrap = 8'({1'b0, req.glyph} - 9'(GLYPH_COUNT));
    end else begin
      glyph_wrap = req.glyph;
    end
    if ({1'b0, req.line} >= 5'(GLYPH_LINES)) begin
      line_wrap = 4'({1'b0, req.line} - 5'(GLYPH_LINES));
    end else begin
      line_wrap = req.line;
    end
    addr = ADDR_W'(32'(glyph_wrap) * GLYPH_LINES + 32'(line_wrap));
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
